@@ hdl/crp_pkg.sv @@
// Package for the conv/relu/pool stack: widths, register codes, config type, helpers.
`timescale 1ns / 1ps
package crp_pkg;

	localparam int DATA_W = 16;
	localparam int FEAT_W = 15;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int FRAC_W = 8;
	localparam int TAPS = 3;
	localparam int REG_IDX_W = 3;

	localparam logic [FEAT_W-1:0] FEAT_MAX = {FEAT_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_FIRST_TAP_A = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_TAP_B = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_TAP_C = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_OFFSET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_TAP_A = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_TAP_B = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_TAP_C = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_OFFSET = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] first_tap_a;
		logic signed [DATA_W-1:0] first_tap_b;
		logic signed [DATA_W-1:0] first_tap_c;
		logic signed [DATA_W-1:0] first_offset;
		logic signed [DATA_W-1:0] second_tap_a;
		logic signed [DATA_W-1:0] second_tap_b;
		logic signed [DATA_W-1:0] second_tap_c;
		logic signed [DATA_W-1:0] second_offset;
	} crp_cfg_t;

	localparam crp_cfg_t CFG_RESET = '{
		first_tap_a: -16'sd256,
		first_tap_b: 16'sd512,
		first_tap_c: -16'sd256,
		first_offset: 16'sd0,
		second_tap_a: 16'sd256,
		second_tap_b: -16'sd256,
		second_tap_c: 16'sd256,
		second_offset: 16'sd0
	};

	// control of one tap cell
	typedef struct packed {
		logic load;
		logic clear;
		logic mul_en;
	} crp_cell_ctl_t;

	function automatic logic signed [ACC_W-1:0] crp_sum(
		input logic signed [PROD_W-1:0] p0,
		input logic signed [PROD_W-1:0] p1,
		input logic signed [PROD_W-1:0] p2,
		input logic signed [DATA_W-1:0] bias
	);
		logic signed [ACC_W-1:0] b;
		b = ACC_W'(bias) <<< FRAC_W;
		return ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + b;
	endfunction

	// floor shift, ReLU, clamp
	function automatic logic [FEAT_W-1:0] crp_finish(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] q;
		q = acc >>> FRAC_W;
		if (acc <= 0)
			return '0;
		else if (q > ACC_W'(FEAT_MAX))
			return FEAT_MAX;
		else
			return q[FEAT_W-1:0];
	endfunction

endpackage

@@ hdl/crp_if.sv @@
// Stream interfaces for samples in and features out.
`timescale 1ns / 1ps
interface crp_in_if;
	logic valid;
	logic ready;
	logic signed [crp_pkg::DATA_W-1:0] sample_value;
	logic frame_last;

	modport source (output valid, output sample_value, output frame_last, input ready);
	modport sink (input valid, input sample_value, input frame_last, output ready);
endinterface

interface crp_out_if;
	logic valid;
	logic ready;
	logic [crp_pkg::FEAT_W-1:0] feature_value;
	logic feature_valid;
	logic frame_end;

	modport source (output valid, output feature_value, output feature_valid,
		output frame_end, input ready);
	modport sink (input valid, input feature_value, input feature_valid,
		input frame_end, output ready);
endinterface

@@ hdl/crp_tap_cell.sv @@
// One window cell: holds a value, passes it along the chain, multiplies by its tap.
`timescale 1ns / 1ps
module crp_tap_cell (
	input  logic clk,
	input  logic arst_n,
	input  crp_pkg::crp_cell_ctl_t ctl,
	input  logic signed [crp_pkg::DATA_W-1:0] d_in,
	input  logic signed [crp_pkg::DATA_W-1:0] tap,
	output logic signed [crp_pkg::DATA_W-1:0] value,
	output logic signed [crp_pkg::PROD_W-1:0] product
);

	logic signed [crp_pkg::DATA_W-1:0] value_q;
	logic signed [crp_pkg::PROD_W-1:0] product_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.clear) begin
			value_q <= '0;
		end else if (ctl.load) begin
			value_q <= d_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			product_q <= value_q * tap;
		end
	end

	assign value = value_q;
	assign product = product_q;

endmodule

@@ hdl/conv_relu_pool_conv_stack_unit.sv @@
// Top level: two three-tap convolution layers with ReLU and a pair max pool between them.
`timescale 1ns / 1ps
// Each accepted sample runs through a short sequencer that drives two chains of three
// tap cells (one per layer): M1 and DONE when no layer-one value is formed; M1, A1, P
// and DONE when it opens a pool pair; M1, A1, P, M2 and DONE when it closes one while
// the layer-two window is still filling; M1, A1, P, M2, A2 and DONE when a layer-two
// value is produced. DONE waits for a free output register (every sample passes that
// step, with or without a result). The input takes the next sample while a result is
// still held at the output; the last sample of a frame always yields one transaction
// with frame_end set, after which all windows are cleared. Config is held across
// frames.
module conv_relu_pool_conv_stack_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [crp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [crp_pkg::DATA_W-1:0] cfg_data,
	crp_in_if.sink samples,
	crp_out_if.source features
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_M1,
		S_A1,
		S_P,
		S_M2,
		S_A2,
		S_DONE
	} state_t;

	state_t state_q;
	crp_pkg::crp_cfg_t cfg_q;

	logic [1:0] sample_fill_q;
	logic [1:0] pooled_fill_q;
	logic pool_phase_q;
	logic [crp_pkg::FEAT_W-1:0] pool_first_q;
	logic [crp_pkg::FEAT_W-1:0] l1_q;
	logic [crp_pkg::FEAT_W-1:0] feat_q;
	logic have2_q;
	logic last_q;

	logic out_valid_q;
	logic [crp_pkg::FEAT_W-1:0] out_value_q;
	logic out_fvalid_q;
	logic out_end_q;

	logic accept;
	logic emit_ok;
	logic emit;
	logic [crp_pkg::FEAT_W-1:0] pool_max;

	crp_pkg::crp_cell_ctl_t ctl1 [crp_pkg::TAPS];
	crp_pkg::crp_cell_ctl_t ctl2 [crp_pkg::TAPS];
	logic signed [crp_pkg::DATA_W-1:0] val1 [crp_pkg::TAPS];
	logic signed [crp_pkg::DATA_W-1:0] val2 [crp_pkg::TAPS];
	logic signed [crp_pkg::PROD_W-1:0] prod1 [crp_pkg::TAPS];
	logic signed [crp_pkg::PROD_W-1:0] prod2 [crp_pkg::TAPS];
	logic signed [crp_pkg::DATA_W-1:0] tap1 [crp_pkg::TAPS];
	logic signed [crp_pkg::DATA_W-1:0] tap2 [crp_pkg::TAPS];

	assign samples.ready = (state_q == S_IDLE);
	assign accept = samples.valid && samples.ready;
	assign emit_ok = !out_valid_q || features.ready;
	assign emit = (state_q == S_DONE) && emit_ok && (last_q || have2_q);
	assign pool_max = (pool_first_q > l1_q) ? pool_first_q : l1_q;

	assign tap1[0] = cfg_q.first_tap_a;
	assign tap1[1] = cfg_q.first_tap_b;
	assign tap1[2] = cfg_q.first_tap_c;
	assign tap2[0] = cfg_q.second_tap_a;
	assign tap2[1] = cfg_q.second_tap_b;
	assign tap2[2] = cfg_q.second_tap_c;

	// cell controls
	logic frame_clear;
	assign frame_clear = (state_q == S_DONE) && emit_ok && last_q;

	always_comb begin
		for (int i = 0; i < crp_pkg::TAPS; i++) begin
			ctl1[i].clear = frame_clear;
			ctl2[i].clear = frame_clear;
			ctl1[i].mul_en = (state_q == S_M1);
			ctl2[i].mul_en = (state_q == S_M2);
			if (i == crp_pkg::TAPS - 1) begin
				ctl1[i].load = accept;
				ctl2[i].load = (state_q == S_P) && pool_phase_q;
			end else begin
				ctl1[i].load = (state_q == S_M1);
				ctl2[i].load = (state_q == S_M2);
			end
		end
	end

	for (genvar g = 0; g < crp_pkg::TAPS; g++) begin : g_cells
		logic signed [crp_pkg::DATA_W-1:0] d1;
		logic signed [crp_pkg::DATA_W-1:0] d2;
		if (g == crp_pkg::TAPS - 1) begin : g_head
			assign d1 = samples.sample_value;
			assign d2 = {1'b0, pool_max};
		end else begin : g_body
			assign d1 = val1[g+1];
			assign d2 = val2[g+1];
		end

		crp_tap_cell u_l1 (
			.clk(clk), .arst_n(arst_n), .ctl(ctl1[g]), .d_in(d1), .tap(tap1[g]),
			.value(val1[g]), .product(prod1[g])
		);

		crp_tap_cell u_l2 (
			.clk(clk), .arst_n(arst_n), .ctl(ctl2[g]), .d_in(d2), .tap(tap2[g]),
			.value(val2[g]), .product(prod2[g])
		);
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= crp_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crp_pkg::REG_FIRST_TAP_A:   cfg_q.first_tap_a <= cfg_data;
				crp_pkg::REG_FIRST_TAP_B:   cfg_q.first_tap_b <= cfg_data;
				crp_pkg::REG_FIRST_TAP_C:   cfg_q.first_tap_c <= cfg_data;
				crp_pkg::REG_FIRST_OFFSET:  cfg_q.first_offset <= cfg_data;
				crp_pkg::REG_SECOND_TAP_A:  cfg_q.second_tap_a <= cfg_data;
				crp_pkg::REG_SECOND_TAP_B:  cfg_q.second_tap_b <= cfg_data;
				crp_pkg::REG_SECOND_TAP_C:  cfg_q.second_tap_c <= cfg_data;
				crp_pkg::REG_SECOND_OFFSET: cfg_q.second_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sample_fill_q <= '0;
			pooled_fill_q <= '0;
			pool_phase_q <= 1'b0;
			pool_first_q <= '0;
			l1_q <= '0;
			feat_q <= '0;
			have2_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_fvalid_q <= 1'b0;
			out_end_q <= 1'b0;
		end else begin
			if (out_valid_q && features.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= samples.frame_last;
						have2_q <= 1'b0;
						state_q <= S_M1;
					end
				end
				S_M1: begin
					if (sample_fill_q >= 2'd2) begin
						state_q <= S_A1;
					end else begin
						sample_fill_q <= sample_fill_q + 2'd1;
						state_q <= S_DONE;
					end
				end
				S_A1: begin
					l1_q <= crp_pkg::crp_finish(crp_pkg::crp_sum(prod1[0], prod1[1],
						prod1[2], cfg_q.first_offset));
					state_q <= S_P;
				end
				S_P: begin
					if (!pool_phase_q) begin
						pool_first_q <= l1_q;
						pool_phase_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						pool_phase_q <= 1'b0;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (pooled_fill_q >= 2'd2) begin
						state_q <= S_A2;
					end else begin
						pooled_fill_q <= pooled_fill_q + 2'd1;
						state_q <= S_DONE;
					end
				end
				S_A2: begin
					feat_q <= crp_pkg::crp_finish(crp_pkg::crp_sum(prod2[0], prod2[1],
						prod2[2], cfg_q.second_offset));
					have2_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (emit_ok) begin
						if (emit) begin
							out_valid_q <= 1'b1;
							out_value_q <= have2_q ? feat_q : '0;
							out_fvalid_q <= have2_q;
							out_end_q <= last_q;
						end
						if (last_q) begin
							sample_fill_q <= '0;
							pooled_fill_q <= '0;
							pool_phase_q <= 1'b0;
							pool_first_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign features.valid = out_valid_q;
	assign features.feature_value = out_value_q;
	assign features.feature_valid = out_fvalid_q;
	assign features.frame_end = out_end_q;

endmodule

@@ dv/crp_feature_checker.sv @@
// Checker for the conv/relu/pool stack: predicts each feature transaction and compares it.
`timescale 1ns / 1ps
module crp_feature_checker import crp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	crp_in_if samples,
	crp_out_if features,
	output int fail_count,
	output int pending,
	output int results_seen,
	output int features_seen
);

	typedef struct packed {
		logic [FEAT_W-1:0] value;
		logic valid;
		logic frame_end;
	} feature_t;

	feature_t feature_due[$];
	crp_cfg_t regs;

	logic signed [DATA_W-1:0] sample_hist [2];
	int sample_count;
	logic [FEAT_W-1:0] pair_held;
	logic pair_open;
	logic [FEAT_W-1:0] pooled_hist [2];
	int pooled_count;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// full-precision sum, floor shift, ReLU, clamp
	function automatic logic [FEAT_W-1:0] layer_tap(
		input longint a, input longint b, input longint c,
		input logic signed [DATA_W-1:0] ta, input logic signed [DATA_W-1:0] tb,
		input logic signed [DATA_W-1:0] tc, input logic signed [DATA_W-1:0] bias
	);
		longint acc;
		acc = longint'(bias) * 256 + a * longint'(ta) + b * longint'(tb) + c * longint'(tc);
		if (acc <= 0)
			return '0;
		if ((acc >>> FRAC_W) > longint'(FEAT_MAX))
			return FEAT_MAX;
		return FEAT_W'(acc >>> FRAC_W);
	endfunction

	function automatic void clear_windows();
		sample_hist[0] = '0;
		sample_hist[1] = '0;
		sample_count = 0;
		pair_held = '0;
		pair_open = 1'b0;
		pooled_hist[0] = '0;
		pooled_hist[1] = '0;
		pooled_count = 0;
	endfunction

	// one sample through both layers; returns 1 when a transaction is due
	function automatic bit advance_stack(input logic signed [DATA_W-1:0] x, input logic last,
		output feature_t r);
		logic [FEAT_W-1:0] l1;
		logic [FEAT_W-1:0] p;
		logic [FEAT_W-1:0] feat;
		bit have;
		have = 1'b0;
		feat = '0;
		if (sample_count >= 2) begin
			l1 = layer_tap(sample_hist[0], sample_hist[1], x, regs.first_tap_a,
				regs.first_tap_b, regs.first_tap_c, regs.first_offset);
			if (!pair_open) begin
				pair_held = l1;
				pair_open = 1'b1;
			end else begin
				p = (pair_held > l1) ? pair_held : l1;
				pair_open = 1'b0;
				if (pooled_count >= 2) begin
					feat = layer_tap(pooled_hist[0], pooled_hist[1], p, regs.second_tap_a,
						regs.second_tap_b, regs.second_tap_c, regs.second_offset);
					have = 1'b1;
				end else begin
					pooled_count++;
				end
				pooled_hist[0] = pooled_hist[1];
				pooled_hist[1] = p;
			end
		end else begin
			sample_count++;
		end
		sample_hist[0] = sample_hist[1];
		sample_hist[1] = x;
		r.value = have ? feat : '0;
		r.valid = have;
		r.frame_end = last;
		if (last)
			clear_windows();
		return have || last;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		feature_t got;
		feature_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			clear_windows();
			feature_due.delete();
			fail_count = 0;
			results_seen = 0;
			features_seen = 0;
			pending <= 0;
		end else begin
			if (features.valid && features.ready) begin
				got.value = features.feature_value;
				got.valid = features.feature_valid;
				got.frame_end = features.frame_end;
				results_seen++;
				if (got.valid)
					features_seen++;
				if (feature_due.size() == 0) begin
					report($sformatf("unexpected transaction value=%0d valid=%b end=%b",
						got.value, got.valid, got.frame_end));
				end else begin
					want = feature_due.pop_front();
					if (got.value != want.value)
						report($sformatf("feature_value %0d, expected %0d", got.value, want.value));
					if (got.valid != want.valid)
						report($sformatf("feature_valid %b, expected %b", got.valid, want.valid));
					if (got.frame_end != want.frame_end)
						report($sformatf("frame_end %b, expected %b", got.frame_end,
							want.frame_end));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_TAP_A: regs.first_tap_a = cfg_data;
					REG_FIRST_TAP_B: regs.first_tap_b = cfg_data;
					REG_FIRST_TAP_C: regs.first_tap_c = cfg_data;
					REG_FIRST_OFFSET: regs.first_offset = cfg_data;
					REG_SECOND_TAP_A: regs.second_tap_a = cfg_data;
					REG_SECOND_TAP_B: regs.second_tap_b = cfg_data;
					REG_SECOND_TAP_C: regs.second_tap_c = cfg_data;
					REG_SECOND_OFFSET: regs.second_offset = cfg_data;
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				if (advance_stack(samples.sample_value, samples.frame_last, want))
					feature_due.push_back(want);
			end
			pending <= feature_due.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the conv/relu/pool stack: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import crp_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETTLE = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	crp_in_if in_ch();
	crp_out_if out_ch();

	int fail_count;
	int pending;
	int results_seen;
	int features_seen;
	int cycles = 0;
	int stall_left = 0;
	int frames_sent = 0;
	int samples_sent = 0;
	int settings_used = 1;
	bit idle_on = 1'b1;
	bit gaps_on = 1'b1;

	conv_relu_pool_conv_stack_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(in_ch),
		.features(out_ch)
	);

	crp_feature_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(in_ch),
		.features(out_ch),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.features_seen(features_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// feature side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 11);
		out_ch.ready <= (stall_left == 0);
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// leaves valid high after the transaction so back-to-back samples need no extra step
	task automatic send(input logic signed [DATA_W-1:0] v, input logic last);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_value <= v;
		in_ch.frame_last <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		samples_sent++;
		if (last)
			frames_sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic write_settings(input crp_cfg_t c);
		put_reg(REG_FIRST_TAP_A, c.first_tap_a);
		put_reg(REG_FIRST_TAP_B, c.first_tap_b);
		put_reg(REG_FIRST_TAP_C, c.first_tap_c);
		put_reg(REG_FIRST_OFFSET, c.first_offset);
		put_reg(REG_SECOND_TAP_A, c.second_tap_a);
		put_reg(REG_SECOND_TAP_B, c.second_tap_b);
		put_reg(REG_SECOND_TAP_C, c.second_tap_c);
		put_reg(REG_SECOND_OFFSET, c.second_offset);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// span 0: any 16-bit value, else within +/- span
	function automatic logic signed [DATA_W-1:0] pick_coeff(input int span);
		if (span == 0)
			return DATA_W'($urandom);
		return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic crp_cfg_t random_settings(input int span);
		crp_cfg_t c;
		c.first_tap_a = pick_coeff(span);
		c.first_tap_b = pick_coeff(span);
		c.first_tap_c = pick_coeff(span);
		c.first_offset = pick_coeff(span);
		c.second_tap_a = pick_coeff(span);
		c.second_tap_b = pick_coeff(span);
		c.second_tap_c = pick_coeff(span);
		c.second_offset = pick_coeff(span);
		return c;
	endfunction

	function automatic logic signed [DATA_W-1:0] sample_pick();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return DATA_W'($urandom);
			4, 5, 6, 7: return DATA_W'(int'($urandom_range(0, 2048)) - 1024);
			8: return 16'sh7fff;
			default: return 16'sh8000;
		endcase
	endfunction

	// mostly frames long enough to reach layer two, some short ones
	task automatic send_frames(input int want);
		int sent;
		int len;
		sent = 0;
		while (sent < want) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 28);
			gaps_on = idle_on && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < len; k++)
				send(sample_pick(), k == len - 1);
			sent += len;
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_value = '0;
		in_ch.frame_last = 1'b0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// short frames, an odd leftover, saturation and mid-frame features
		send(16'sh7fff, 1'b1);
		send(16'sh8000, 1'b0);
		send(16'sh7fff, 1'b1);
		send(16'sd100, 1'b0);
		send(-16'sd50, 1'b0);
		send(16'sd300, 1'b1);
		for (int i = 0; i < 8; i++)
			send((i % 2) ? 16'sh7fff : 16'sh8000, i == 7);
		for (int i = 0; i < 11; i++)
			send(DATA_W'(((i * 797) % 3000) - 1500), i == 10);
		settle();

		write_settings(random_settings(0));
		send_frames(110);
		settle();

		write_settings('{default: 16'sh7fff});
		send_frames(110);
		settle();

		write_settings('{default: 16'sh8000});
		send_frames(110);
		settle();

		write_settings(random_settings(512));
		send_frames(110);
		settle();

		// closing stretch at full rate
		idle_on = 1'b0;
		write_settings(CFG_RESET);
		send_frames(110);
		settle();

		$display("Covered %0d samples in %0d frames under %0d register settings",
			samples_sent, frames_sent, settings_used);
		$display("%0d transactions checked, %0d carrying a layer-two feature",
			results_seen, features_seen);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ conv_relu_pool_conv_stack_unit.f @@
hdl/crp_pkg.sv
hdl/crp_if.sv
hdl/crp_tap_cell.sv
hdl/conv_relu_pool_conv_stack_unit.sv
dv/crp_feature_checker.sv
dv/testbench.sv
